// ----- sv/ray_transfer_compositor_assert.svh -----
// Assertion macros shared by the compositor RTL.
`ifndef RAY_TRANSFER_COMPOSITOR_ASSERT_SVH
`define RAY_TRANSFER_COMPOSITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rtc_pkg.sv -----
// Shared constants, types and helpers of the ray transfer compositor.
package rtc_pkg;

	localparam int TABLE_BINS = 256;
	localparam int TABLE_AW   = $clog2(TABLE_BINS);
	localparam int SAMPLE_W   = 24;
	localparam int POWER_W    = 4;
	localparam int ACC_W      = 16;
	localparam int Q_W        = 17;
	localparam int CFG_AW     = 2;
	localparam int CFG_DW     = 24;

	localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [24:0] DIV255_M = 25'd16843010;

	localparam logic [CFG_AW-1:0] CFG_VALUE_MIN     = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_BIN_SCALE     = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_OPACITY_POWER = 2'd2;

	localparam logic [SAMPLE_W-1:0] VALUE_MIN_RST     = 24'd2560;
	localparam logic [CFG_DW-1:0]   BIN_SCALE_RST     = 24'd3355443;
	localparam logic [POWER_W-1:0]  OPACITY_POWER_RST = 4'd5;

	typedef enum logic {
		MODE_LOAD   = 1'b0,
		MODE_SAMPLE = 1'b1
	} rtc_mode_t;

	typedef struct packed {
		logic [7:0] opacity;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rtc_entry_t;

	typedef struct packed {
		logic               start;
		logic [Q_W-1:0]     t;
		logic [POWER_W-1:0] power;
	} rtc_pow_req_t;

	typedef struct packed {
		logic           busy;
		logic           done;
		logic [Q_W-1:0] tp;
	} rtc_pow_stat_t;

	// Transparency round((255 - op) * 65536 / 255) written as x * 257 plus a rounding bit.
	function automatic logic [Q_W-1:0] transparency(input logic [7:0] op);
		logic [7:0] x;
		x = 8'hFF - op;
		return {1'b0, x, x} + Q_W'(x[7]);
	endfunction

endpackage

// ----- sv/rtc_table_ram.sv -----
// Single-port-write, registered-read RAM holding the transfer table.
module rtc_table_ram #(
	parameter int DEPTH = 256,
	parameter int DW    = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/rtc_opacity_pow.sv -----
// Iterative unit that raises the entry transparency to the correction exponent.
module rtc_opacity_pow (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtc_pkg::rtc_pow_req_t  req,
	output rtc_pkg::rtc_pow_stat_t stat
);
	import rtc_pkg::*;

	logic               busy_q;
	logic [POWER_W-1:0] cnt_q;
	logic [Q_W-1:0]     t_q;
	logic [Q_W-1:0]     tp_q;
	logic [33:0]        prod;
	logic [33:0]        rnd;

	assign prod = tp_q * t_q;
	assign rnd  = prod + 34'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.power;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - POWER_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			t_q  <= req.t;
			tp_q <= ONE_Q16;
		end else if (busy_q && cnt_q != '0) begin
			tp_q <= rnd[32:16];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);
	assign stat.tp   = tp_q;

endmodule

// ----- sv/ray_transfer_compositor.sv -----
// Top level of the ray transfer compositor: sequencer, accumulators and ports.
// A load beat (tuser 0) writes one transfer table entry. A composited sample beat (tuser 1)
// waits on the iterative exponent unit, one 17x17 multiply per cycle while busy. A sample
// below value_min goes from the multiply state straight to finish, and one whose bin lies past
// the table end goes there from the bin state. A last sample waits in its final cycle while
// the previous pixel still sits unaccepted in the output register. The table needs no
// clearing after reset, so the block accepts beats right away.
`include "ray_transfer_compositor_assert.svh"

module ray_transfer_compositor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// table_index, entry_red, entry_green, entry_blue, entry_opacity, sample_value
	input  logic [63:0]                s_tdata,
	// mode
	input  logic                       s_tuser,
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// pixel_red, pixel_green, pixel_blue
	output logic [23:0]                m_tdata,
	input  logic                       cfg_we,
	input  logic [rtc_pkg::CFG_AW-1:0] cfg_index,
	input  logic [rtc_pkg::CFG_DW-1:0] cfg_data
);
	import rtc_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_BIN    = 3'd2;
	localparam logic [2:0] ST_LOOK   = 3'd3;
	localparam logic [2:0] ST_POW    = 3'd4;
	localparam logic [2:0] ST_WT     = 3'd5;
	localparam logic [2:0] ST_DIV    = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	localparam int IDX_EXT_W = ((TABLE_AW > 8) ? TABLE_AW : 8) + 1;

	function automatic logic [ACC_W-1:0] sat16(input logic [ACC_W+1:0] v);
		return (v > (ACC_W+2)'(16'hFFFF)) ? 16'hFFFF : v[ACC_W-1:0];
	endfunction

	function automatic logic [7:0] to_byte(input logic [ACC_W-1:0] acc);
		logic [23:0] p;
		p = {acc, 8'b0} - {8'b0, acc};
		return p[23:16];
	endfunction

	function automatic logic [Q_W-1:0] div255(input logic [23:0] n);
		logic [48:0] p;
		p = n * DIV255_M;
		return p[48:32];
	endfunction

	logic [2:0]          state_q;
	logic [SAMPLE_W-1:0] vmin_q;
	logic [CFG_DW-1:0]   scale_q;
	logic [POWER_W-1:0]  power_q;
	logic [24:0]         diff_q;
	logic                last_q;
	logic [47:0]         prod_q;
	rtc_entry_t          col_q;
	logic [33:0]         wprod_q;
	logic [23:0]         nr_q;
	logic [23:0]         ng_q;
	logic [23:0]         nb_q;
	logic [ACC_W-1:0]    racc_q;
	logic [ACC_W-1:0]    gacc_q;
	logic [ACC_W-1:0]    bacc_q;
	logic [ACC_W-1:0]    oacc_q;
	logic                m_tvalid_q;
	logic [23:0]         m_tdata_q;

	logic                 accept;
	logic [SAMPLE_W-1:0]  in_sample;
	logic [IDX_EXT_W-1:0] idx_ext;
	logic                 wr_en;
	rtc_entry_t           wr_entry;
	logic [24:0]          diff;
	logic [47:0]          mul;
	logic [23:0]          bin;
	logic                 bin_ok;
	logic                 rd_en;
	rtc_entry_t           rd_entry;
	logic [Q_W-1:0]       s_op;
	logic [Q_W-1:0]       rem;
	logic [33:0]          wsum;
	logic [Q_W-1:0]       w;
	logic [24:0]          pr;
	logic [24:0]          pg;
	logic [24:0]          pb;
	logic                 emit;
	rtc_pow_req_t         pow_req;
	rtc_pow_stat_t        pow_stat;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_sample = s_tdata[63:40];
	assign idx_ext   = IDX_EXT_W'(s_tdata[7:0]);
	assign wr_en     = accept && (s_tuser == MODE_LOAD) && (idx_ext < IDX_EXT_W'(TABLE_BINS));

	assign wr_entry.red     = s_tdata[15:8];
	assign wr_entry.green   = s_tdata[23:16];
	assign wr_entry.blue    = s_tdata[31:24];
	assign wr_entry.opacity = s_tdata[39:32];

	assign diff   = {in_sample[SAMPLE_W-1], in_sample} - {vmin_q[SAMPLE_W-1], vmin_q};
	assign mul    = diff_q[23:0] * scale_q;
	assign bin    = prod_q[47:24];
	assign bin_ok = bin < 24'(TABLE_BINS);
	assign rd_en  = (state_q == ST_BIN) && bin_ok;

	assign s_op = ONE_Q16 - pow_stat.tp;
	assign rem  = ONE_Q16 - {1'b0, oacc_q};
	assign wsum = wprod_q + 34'd32768;
	assign w    = wsum[32:16];
	assign pr   = w * col_q.red;
	assign pg   = w * col_q.green;
	assign pb   = w * col_q.blue;

	assign emit = (state_q == ST_FINISH) && last_q && (!m_tvalid_q || m_tready);

	assign pow_req.start = (state_q == ST_LOOK);
	assign pow_req.t     = transparency(rd_entry.opacity);
	assign pow_req.power = power_q;

	rtc_table_ram #(
		.DEPTH (TABLE_BINS),
		.DW    ($bits(rtc_entry_t))
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_ext[TABLE_AW-1:0]),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (bin[TABLE_AW-1:0]),
		.rd_data (rd_entry)
	);

	rtc_opacity_pow u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pow_req),
		.stat   (pow_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmin_q  <= VALUE_MIN_RST;
			scale_q <= BIN_SCALE_RST;
			power_q <= OPACITY_POWER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VALUE_MIN:     vmin_q  <= cfg_data;
				CFG_BIN_SCALE:     scale_q <= cfg_data;
				CFG_OPACITY_POWER: power_q <= cfg_data[POWER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			racc_q     <= '0;
			gacc_q     <= '0;
			bacc_q     <= '0;
			oacc_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser != MODE_LOAD) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= diff_q[24] ? ST_FINISH : ST_BIN;
				end
				ST_BIN: begin
					state_q <= bin_ok ? ST_LOOK : ST_FINISH;
				end
				ST_LOOK: begin
					state_q <= ST_POW;
				end
				ST_POW: begin
					if (pow_stat.done) begin
						state_q <= ST_WT;
					end
				end
				ST_WT: begin
					oacc_q  <= sat16((ACC_W+2)'(oacc_q) + (ACC_W+2)'(w));
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					racc_q  <= sat16((ACC_W+2)'(racc_q) + (ACC_W+2)'(div255(nr_q)));
					gacc_q  <= sat16((ACC_W+2)'(gacc_q) + (ACC_W+2)'(div255(ng_q)));
					bacc_q  <= sat16((ACC_W+2)'(bacc_q) + (ACC_W+2)'(div255(nb_q)));
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (emit) begin
						racc_q  <= '0;
						gacc_q  <= '0;
						bacc_q  <= '0;
						oacc_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q <= diff;
			last_q <= s_tlast;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul;
		end
		if (state_q == ST_LOOK) begin
			col_q <= rd_entry;
		end
		if (state_q == ST_POW && pow_stat.done) begin
			wprod_q <= rem * s_op;
		end
		if (state_q == ST_WT) begin
			nr_q <= pr[23:0] + 24'd127;
			ng_q <= pg[23:0] + 24'd127;
			nb_q <= pb[23:0] + 24'd127;
		end
		if (emit) begin
			m_tdata_q <= {to_byte(bacc_q), to_byte(gacc_q), to_byte(racc_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`RTC_ASSERT_IMP(a_pow_done_in_wait, clk, arst_n, pow_stat.done, state_q == ST_POW, "exponent unit finished outside its wait state")
	`RTC_ASSERT_IMP(a_pow_busy_in_wait, clk, arst_n, state_q == ST_POW, pow_stat.busy, "waiting on an idle exponent unit")
	`RTC_ASSERT_NXT(a_read_then_look, clk, arst_n, rd_en, state_q == ST_LOOK, "table read data not consumed in the next cycle")
	`RTC_ASSERT_NXT(a_out_only_on_last, clk, arst_n, !m_tvalid_q && !emit, !m_tvalid_q, "pixel beat raised without a last sample")
	`RTC_ASSERT_NXT(a_clear_after_emit, clk, arst_n, emit, racc_q == '0 && gacc_q == '0 && bacc_q == '0 && oacc_q == '0, "accumulators not cleared after a pixel")

endmodule
